// ----- rtl/aiq_pkg.sv -----
// Shared types and constants for the absmax int8 quantizer.
// Used by every module of the block; depends on nothing.
package aiq_pkg;

   localparam logic [1:0] OP_SCAN  = 2'd0;
   localparam logic [1:0] OP_QUANT = 2'd1;
   localparam logic [1:0] OP_LOAD  = 2'd2;

   localparam logic KIND_SCALE = 1'b0;
   localparam logic KIND_QUANT = 1'b1;

   localparam logic [31:0] F_ZERO    = 32'h0000_0000;
   localparam logic [31:0] F_ONE     = 32'h3F80_0000;
   localparam logic [31:0] F_127     = 32'h42FE_0000;
   localparam logic [31:0] F_MAX_MIN = 32'h2B8C_BCCC;
   localparam logic [31:0] MAG_MASK  = 32'h7FFF_FFFF;
   localparam logic [7:0]  EXP_ALL   = 8'hFF;

   localparam logic [7:0] Q_MAX = 8'd127;

   // Quotient bits produced by the divider, one per cycle.
   localparam int DIV_STEPS = 26;

   typedef enum logic [1:0] {
      CMD_QUANT,
      CMD_FINISH,
      CMD_LOAD
   } aiq_cmd_kind_type;

   typedef struct packed {
      aiq_cmd_kind_type kind;
      logic [31:0]      value;
      logic             last;
   } aiq_cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_NORM,
      S_ROUND,
      S_DIV_SCALE,
      S_DIV_RECIP,
      S_DIV_LOAD,
      S_EMIT
   } aiq_state_type;

   typedef struct packed {
      logic        pop;
      logic        div_start;
      logic [31:0] div_num;
      logic [31:0] div_den;
      logic        out_load;
   } aiq_ctrl_type;

endpackage

// ----- rtl/aiq_fdiv.sv -----
// Iterative IEEE single divider, one quotient bit per cycle, round to nearest even.
// Operands must be normal numbers; results may be subnormal. Uses aiq_pkg.
module aiq_fdiv import aiq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] num,
   input  logic [31:0] den,
   output logic        busy,
   output logic        done,
   output logic [31:0] quo
);

   logic               run_ff, run_in;
   logic               fin_ff, fin_in;
   logic               done_ff, done_in;
   logic [25:0]        rem_ff, rem_in;
   logic [23:0]        dm_ff, dm_in;
   logic [25:0]        q_ff, q_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic signed [9:0]  exp_ff, exp_in;
   logic               sign_ff, sign_in;
   logic [31:0]        quo_ff, quo_in;

   logic               ge;
   logic [25:0]        diff;
   logic               hi;
   logic signed [9:0]  e_n;
   logic signed [9:0]  sh_w;
   logic [4:0]         sh;
   logic [23:0]        m24;
   logic               g;
   logic               s;
   logic [24:0]        x;
   logic [24:0]        x2;
   logic               lost;
   logic [23:0]        mf;
   logic               gf;
   logic               sf;
   logic [7:0]         efield;
   logic [30:0]        packed_w;

   always_comb begin
      ge   = rem_ff >= {2'b00, dm_ff};
      diff = ge ? (rem_ff - {2'b00, dm_ff}) : rem_ff;

      hi  = q_ff[25];
      e_n = hi ? exp_ff : (exp_ff - 10'sd1);
      m24 = hi ? q_ff[25:2] : q_ff[24:1];
      g   = hi ? q_ff[1] : q_ff[0];
      s   = (hi & q_ff[0]) | (rem_ff != 26'd0);

      // A result below the normal range is shifted right into subnormal form.
      sh_w = 10'sd1 - e_n;
      if (e_n > 10'sd0) begin
         sh = 5'd0;
      end else if (sh_w > 10'sd25) begin
         sh = 5'd25;
      end else begin
         sh = sh_w[4:0];
      end
      x    = {m24, g};
      x2   = x >> sh;
      lost = |(x & ((25'd1 << sh) - 25'd1));
      mf   = x2[24:1];
      gf   = x2[0];
      sf   = s | lost;
      efield = (e_n > 10'sd0) ? e_n[7:0] : 8'd0;
      packed_w = {efield, mf[22:0]} + {30'd0, gf & (sf | mf[0])};
   end

   always_comb begin
      run_in  = run_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      rem_in  = rem_ff;
      dm_in   = dm_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      exp_in  = exp_ff;
      sign_in = sign_ff;
      quo_in  = quo_ff;
      if (start) begin
         run_in  = 1'b1;
         rem_in  = {3'b001, num[22:0]};
         dm_in   = {1'b1, den[22:0]};
         q_in    = 26'd0;
         cnt_in  = 5'd0;
         exp_in  = $signed({2'b00, num[30:23]}) - $signed({2'b00, den[30:23]}) + 10'sd127;
         sign_in = num[31] ^ den[31];
      end else if (run_ff) begin
         rem_in = {diff[24:0], 1'b0};
         q_in   = {q_ff[24:0], ge};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(DIV_STEPS - 1)) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end else if (fin_ff) begin
         done_in = 1'b1;
         quo_in  = {sign_ff, packed_w};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      dm_ff   <= dm_in;
      q_ff    <= q_in;
      cnt_ff  <= cnt_in;
      exp_ff  <= exp_in;
      sign_ff <= sign_in;
      quo_ff  <= quo_in;
   end

   assign busy = run_ff | fin_ff;
   assign done = done_ff;
   assign quo  = quo_ff;

   assert property (@(posedge clock) disable iff (reset) start |-> !(run_ff || fin_ff))
      else $error("divider started while busy");
   assert property (@(posedge clock) disable iff (reset) fin_ff |=> done_ff && !run_ff)
      else $error("divider finish did not deliver a result");

endmodule

// ----- rtl/aiq_front.sv -----
// Front end: accepts items, folds scan samples into the running maximum and
// turns scan ends, quantizes and valid loads into commands. Uses aiq_pkg.
module aiq_front import aiq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_value,
   input  logic        req_last,
   input  logic        q_full,
   output logic        push,
   output aiq_cmd_type entry
);

   logic [31:0] max_ff, max_in;
   logic        accept;
   logic [31:0] mag;
   logic [31:0] folded;
   logic [31:0] final_max;

   assign req_stall = q_full;
   assign accept    = req_valid & ~q_full;

   always_comb begin
      mag = req_value & MAG_MASK;
      // Magnitudes of finite floats order the same way as their bit patterns.
      folded = ((mag[30:23] != EXP_ALL) && (mag > max_ff)) ? mag : max_ff;
      final_max = (folded < F_MAX_MIN) ? F_ONE : folded;

      max_in      = max_ff;
      push        = 1'b0;
      entry.kind  = CMD_QUANT;
      entry.value = req_value;
      entry.last  = req_last;
      if (accept) begin
         case (req_opcode)
            OP_SCAN: begin
               if (req_last) begin
                  max_in      = F_ZERO;
                  push        = 1'b1;
                  entry.kind  = CMD_FINISH;
                  entry.value = final_max;
               end else begin
                  max_in = folded;
               end
            end
            OP_QUANT: begin
               push = 1'b1;
               if (req_value[30:23] == EXP_ALL) begin
                  entry.value = F_ZERO;
               end
            end
            OP_LOAD: begin
               entry.kind = CMD_LOAD;
               push = (req_value[30:23] != 8'd0) && (req_value[30:23] != EXP_ALL);
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= F_ZERO;
      end else begin
         max_ff <= max_in;
      end
   end

endmodule

// ----- rtl/aiq_queue.sv -----
// Two-entry command queue between the front and back ends.
// Uses aiq_pkg for the command type.
module aiq_queue import aiq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  aiq_cmd_type entry,
   input  logic        pop,
   output logic        head_valid,
   output aiq_cmd_type head,
   output logic        full
);

   aiq_cmd_type mem_ff [2];
   logic        wr_ff, wr_in;
   logic        rd_ff, rd_in;
   logic [1:0]  cnt_ff, cnt_in;

   assign head_valid = cnt_ff != 2'd0;
   assign full       = cnt_ff == 2'd2;
   assign head       = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= entry;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("push into a full queue");
   assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("pop from an empty queue");

endmodule

// ----- rtl/aiq_back.sv -----
// Back end: runs quantize, end-of-scan and load-scale commands, holds the
// reciprocal scale and the output register. Uses aiq_pkg and aiq_fdiv.
module aiq_back import aiq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  aiq_cmd_type        head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_kind,
   output logic [31:0]        rsp_scale_bits,
   output logic signed [7:0]  rsp_quant,
   output logic               rsp_end_mark
);

   aiq_state_type     state_ff, state_in;
   aiq_ctrl_type      ctrl;

   logic [31:0]       recip_ff, recip_in;
   logic [31:0]       m_ff;
   logic [47:0]       prod_ff, prod_in;
   logic signed [9:0] pexp_ff, pexp_in;
   logic              psign_ff;
   logic              last_ff;

   logic              res_kind_ff;
   logic [31:0]       res_scale_ff, res_scale_in;
   logic [7:0]        res_quant_ff, res_quant_in;

   logic              rsp_valid_ff;
   logic              rsp_kind_ff;
   logic [31:0]       rsp_scale_ff;
   logic [7:0]        rsp_quant_ff;
   logic              rsp_end_ff;

   logic              div_busy;
   logic              div_done;
   logic [31:0]       div_quo;
   logic              out_free;

   logic [7:0]        ea, eb;
   logic [23:0]       ma, mb;
   logic [24:0]       r24;
   logic [25:0]       rq;
   logic [4:0]        k;
   logic [7:0]        qc;

   assign out_free = ~rsp_valid_ff | ~rsp_stall;

   aiq_fdiv u_div (
      .clock (clock),
      .reset (reset),
      .start (ctrl.div_start),
      .num   (ctrl.div_num),
      .den   (ctrl.div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               case (head.kind)
                  CMD_QUANT:  state_in = S_NORM;
                  CMD_FINISH: state_in = S_DIV_SCALE;
                  CMD_LOAD:   state_in = S_DIV_LOAD;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_NORM: begin
            if (prod_ff == 48'd0) begin
               state_in = S_EMIT;
            end else if (prod_ff[47]) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND:     state_in = S_EMIT;
         S_DIV_SCALE: if (div_done) state_in = S_DIV_RECIP;
         S_DIV_RECIP: if (div_done) state_in = S_EMIT;
         S_DIV_LOAD:  if (div_done) state_in = S_IDLE;
         S_EMIT:      if (out_free) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      ctrl.pop       = 1'b0;
      ctrl.div_start = 1'b0;
      ctrl.div_num   = F_ONE;
      ctrl.div_den   = head.value;
      ctrl.out_load  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            ctrl.pop = head_valid;
            if (head_valid && (head.kind == CMD_FINISH)) begin
               ctrl.div_start = 1'b1;
               ctrl.div_num   = head.value;
               ctrl.div_den   = F_127;
            end else if (head_valid && (head.kind == CMD_LOAD)) begin
               ctrl.div_start = 1'b1;
            end
         end
         S_DIV_SCALE: begin
            if (div_done) begin
               ctrl.div_start = 1'b1;
               ctrl.div_num   = F_127;
               ctrl.div_den   = m_ff;
            end
         end
         S_EMIT: ctrl.out_load = out_free;
         default: ctrl.out_load = 1'b0;
      endcase
   end

   assign pop = ctrl.pop;

   // Product of the sample and the reciprocal; subnormals use exponent one.
   always_comb begin
      ea = (head.value[30:23] == 8'd0) ? 8'd1 : head.value[30:23];
      eb = (recip_ff[30:23] == 8'd0) ? 8'd1 : recip_ff[30:23];
      ma = {head.value[30:23] != 8'd0, head.value[22:0]};
      mb = {recip_ff[30:23] != 8'd0, recip_ff[22:0]};
      prod_in = prod_ff;
      pexp_in = pexp_ff;
      if (state_ff == S_IDLE) begin
         prod_in = {24'd0, ma} * {24'd0, mb};
         pexp_in = $signed({2'b00, ea}) + $signed({2'b00, eb}) - 10'sd253;
      end else if (state_ff == S_NORM && !prod_ff[47] && prod_ff != 48'd0) begin
         if (prod_ff[47:40] == 8'd0) begin
            prod_in = {prod_ff[39:0], 8'd0};
            pexp_in = pexp_ff - 10'sd8;
         end else begin
            prod_in = {prod_ff[46:0], 1'b0};
            pexp_in = pexp_ff - 10'sd1;
         end
      end
   end

   // The product is first rounded to single precision, then half away from zero.
   always_comb begin
      r24 = {1'b0, prod_ff[47:24]}
          + {24'd0, prod_ff[23] & ((|prod_ff[22:0]) | prod_ff[24])};
      k   = 5'd23 - pexp_ff[4:0];
      rq  = ({1'b0, r24} + (26'd1 << (k - 5'd1))) >> k;
      if (pexp_ff < -10'sd2) begin
         qc = 8'd0;
      end else if (pexp_ff > 10'sd6 || rq > {18'd0, Q_MAX}) begin
         qc = Q_MAX;
      end else begin
         qc = rq[7:0];
      end
   end

   always_comb begin
      res_quant_in = res_quant_ff;
      res_scale_in = res_scale_ff;
      recip_in     = recip_ff;
      if (state_ff == S_NORM && prod_ff == 48'd0) begin
         res_quant_in = 8'd0;
      end else if (state_ff == S_ROUND) begin
         res_quant_in = psign_ff ? (8'd0 - qc) : qc;
      end
      if (state_ff == S_DIV_SCALE && div_done) begin
         res_scale_in = div_quo;
      end
      if ((state_ff == S_DIV_RECIP || state_ff == S_DIV_LOAD) && div_done) begin
         recip_in = div_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         recip_ff     <= F_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         recip_ff <= recip_in;
         if (ctrl.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      prod_ff      <= prod_in;
      pexp_ff      <= pexp_in;
      res_quant_ff <= res_quant_in;
      res_scale_ff <= res_scale_in;
      if (ctrl.pop) begin
         m_ff        <= head.value;
         psign_ff    <= head.value[31] ^ recip_ff[31];
         last_ff     <= head.last;
         res_kind_ff <= (head.kind == CMD_QUANT) ? KIND_QUANT : KIND_SCALE;
      end
      if (ctrl.out_load) begin
         rsp_kind_ff  <= res_kind_ff;
         rsp_scale_ff <= (res_kind_ff == KIND_SCALE) ? res_scale_ff : 32'd0;
         rsp_quant_ff <= (res_kind_ff == KIND_QUANT) ? res_quant_ff : 8'd0;
         rsp_end_ff   <= last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_scale_bits = rsp_scale_ff;
   assign rsp_quant      = $signed(rsp_quant_ff);
   assign rsp_end_mark   = rsp_end_ff;

   assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV_SCALE || state_ff == S_DIV_RECIP ||
                    state_ff == S_DIV_LOAD))
      else $error("divider result arrived with no command waiting for it");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV_RECIP || state_ff == S_DIV_LOAD) |-> (div_busy || div_done))
      else $error("waiting on an idle divider");

endmodule

// ----- rtl/absmax_int8_quantizer.sv -----
// Per-tensor symmetric absmax int8 quantizer on single-precision floats.
// Scan items without the last flag are absorbed at the front end, one per cycle while the
// queue is not full. A quantize result passes the product register, normalize steps,
// rounding and the output register; a zero product skips rounding, subnormals take more
// normalize steps. An end-of-scan item runs two divisions before its scale is valid; a
// load-scale item holds the back end for one division. A two-entry queue lets the front
// keep accepting meanwhile. Synchronous reset zeroes the maximum, reciprocal 1.0.
module absmax_int8_quantizer import aiq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_opcode,
   input  logic [31:0]       req_value,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_kind,
   output logic [31:0]       rsp_scale_bits,
   output logic signed [7:0] rsp_quant,
   output logic              rsp_end_mark
);

   logic        q_full;
   logic        q_push;
   logic        q_pop;
   logic        q_valid;
   aiq_cmd_type q_entry;
   aiq_cmd_type q_head;

   aiq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .req_value  (req_value),
      .req_last   (req_last),
      .q_full     (q_full),
      .push       (q_push),
      .entry      (q_entry)
   );

   aiq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .entry      (q_entry),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head       (q_head),
      .full       (q_full)
   );

   aiq_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (q_valid),
      .head           (q_head),
      .pop            (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_scale_bits (rsp_scale_bits),
      .rsp_quant      (rsp_quant),
      .rsp_end_mark   (rsp_end_mark)
   );

endmodule

// ----- verif/tb_absmax_int8_quantizer.sv -----
// Self-checking testbench for absmax_int8_quantizer: single-precision scan, quantize and
// load-scale items against a bit-exact predictor held in a small scoreboard class.
// Depends on aiq_pkg and the absmax_int8_quantizer RTL only.
module tb_absmax_int8_quantizer import aiq_pkg::*; ();

   localparam logic [1:0] OP_NONE = 2'd3;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 80;

   typedef struct {
      logic        kind;
      logic [31:0] scale_bits;
      logic [7:0]  quant;
      logic        end_mark;
   } quant_result_type;

   class quant_scoreboard_type;
      quant_result_type expected_q[$];
      logic [31:0] running_max;
      logic [31:0] recip_scale;
      int errors;
      int scale_count;
      int quant_count;

      function new();
         running_max = F_ZERO;
         recip_scale = F_ONE;
         errors = 0;
         scale_count = 0;
         quant_count = 0;
      endfunction

      task report(string what, logic [31:0] got, logic [31:0] want);
         $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want,
                  scale_count + quant_count);
         errors++;
      endtask

      static function real f32_to_real(logic [31:0] b);
         logic [10:0] dexp;
         real r;
         if (b[30:23] == 8'd0) begin
            r = real'(b[22:0]) / (2.0 ** 149);
            return b[31] ? -r : r;
         end
         dexp = {3'b0, b[30:23]} + 11'd896;
         return $bitstoreal({b[31], dexp, b[22:0], 29'b0});
      endfunction

      // Round a double to single precision, nearest even, subnormals included.
      static function logic [31:0] real_to_f32(real r);
         logic [63:0] d;
         logic [63:0] m;
         logic [63:0] q;
         logic [63:0] rem;
         logic [63:0] half;
         logic        sgn;
         int          e;
         int          sh;
         d = $realtobits(r);
         sgn = d[63];
         if (d[62:52] == 11'd0) return {sgn, 31'b0};
         if (d[62:52] == 11'h7FF) return {sgn, EXP_ALL, 23'b0};
         e = int'(d[62:52]) - 1023 + 127;
         m = {11'b0, 1'b1, d[51:0]};
         sh = (e < 1) ? 29 + 1 - e : 29;
         if (sh > 60) return {sgn, 31'b0};
         q = m >> sh;
         rem = m & ((64'd1 << sh) - 64'd1);
         half = 64'd1 << (sh - 1);
         if (rem > half || (rem == half && q[0])) q = q + 64'd1;
         if (e < 1) return {sgn, q[30:0]};
         if (q == (64'd1 << 24)) begin
            q = q >> 1;
            e++;
         end
         if (e >= 255) return {sgn, EXP_ALL, 23'b0};
         return {sgn, e[7:0], q[22:0]};
      endfunction

      static function logic [7:0] round_to_int8(logic [31:0] p);
         real r;
         real frac;
         int  i;
         if (p[30:23] == EXP_ALL) begin
            if (p[22:0] != 23'd0) return 8'd0;
            return p[31] ? -Q_MAX : Q_MAX;
         end
         r = f32_to_real(p);
         if (r >= 127.0) return Q_MAX;
         if (r <= -127.0) return -Q_MAX;
         i = $rtoi(r);
         frac = r - real'(i);
         if (frac >= 0.5) i++;
         else if (frac <= -0.5) i--;
         return i[7:0];
      endfunction

      function void note_item(logic [1:0] op, logic [31:0] v, logic last);
         logic [31:0] mag;
         logic [31:0] x;
         real         mr;
         quant_result_type res;
         case (op)
            OP_SCAN: begin
               mag = v & MAG_MASK;
               if (mag[30:23] != EXP_ALL && mag > running_max) running_max = mag;
               if (last) begin
                  mag = (running_max < F_MAX_MIN) ? F_ONE : running_max;
                  mr = f32_to_real(mag);
                  res.kind = KIND_SCALE;
                  res.scale_bits = real_to_f32(mr / 127.0);
                  res.quant = 8'd0;
                  res.end_mark = last;
                  recip_scale = real_to_f32(127.0 / mr);
                  running_max = F_ZERO;
                  expected_q.push_back(res);
               end
            end
            OP_QUANT: begin
               x = (v[30:23] == EXP_ALL) ? F_ZERO : v;
               res.kind = KIND_QUANT;
               res.scale_bits = F_ZERO;
               res.quant = round_to_int8(real_to_f32(f32_to_real(x) *
                                                     f32_to_real(recip_scale)));
               res.end_mark = last;
               expected_q.push_back(res);
            end
            OP_LOAD: begin
               if (v[30:23] != 8'd0 && v[30:23] != EXP_ALL)
                  recip_scale = real_to_f32(1.0 / f32_to_real(v));
            end
            default: ;
         endcase
      endfunction

      task check_result(logic kind, logic [31:0] scale_bits, logic [7:0] quant,
                        logic end_mark);
         quant_result_type want;
         if (expected_q.size() == 0) begin
            report("unexpected result", {31'b0, kind}, 32'd0);
            return;
         end
         want = expected_q.pop_front();
         if (kind !== want.kind) report("kind", {31'b0, kind}, {31'b0, want.kind});
         if (scale_bits !== want.scale_bits) report("scale_bits", scale_bits, want.scale_bits);
         if (quant !== want.quant) report("quant", {24'b0, quant}, {24'b0, want.quant});
         if (end_mark !== want.end_mark)
            report("end_mark", {31'b0, end_mark}, {31'b0, want.end_mark});
         if (want.kind == KIND_SCALE) scale_count++;
         else quant_count++;
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_opcode;
   logic [31:0]       req_value;
   logic              req_last;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_kind;
   logic [31:0]       rsp_scale_bits;
   logic signed [7:0] rsp_quant;
   logic              rsp_end_mark;

   quant_scoreboard_type sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int items_sent = 0;
   int idle_cycles = 0;

   absmax_int8_quantizer u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Accepted items on both channels are sampled at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_item(req_opcode, req_value, req_last);
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_kind, rsp_scale_bits, rsp_quant, rsp_end_mark);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("absmax_int8_quantizer verification failed");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task send_item(logic [1:0] op, logic [31:0] v, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         req_opcode <= 2'($urandom);
         req_value <= $urandom;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_value <= v;
      req_last <= last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (op != OP_NONE) items_sent++;
   endtask

   task wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.expected_q.size() != 0) @(negedge clock);
   endtask

   function automatic logic [31:0] rand_float(int center);
      int e;
      e = center + int'($urandom_range(8)) - 6;
      if (e < 0) e = 0;
      if (e > 254) e = 254;
      return {1'($urandom), e[7:0], 23'($urandom)};
   endfunction

   task random_part(int target);
      int pick;
      int n;
      int ce;
      while (items_sent < target) begin
         pick = $urandom_range(99);
         ce = ($urandom_range(9) == 0) ? $urandom_range(1, 254) : $urandom_range(100, 150);
         if (pick < 60) begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
               send_item(OP_SCAN, rand_float(ce), i == n - 1);
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
               send_item(OP_QUANT, rand_float(ce), 1'($urandom));
         end else if (pick < 75) begin
            send_item(OP_LOAD, rand_float(ce), 1'($urandom));
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
               send_item(OP_QUANT, rand_float(ce + 3), 1'($urandom));
         end else begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
               send_item(2'($urandom), $urandom, 1'($urandom));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_opcode = OP_SCAN;
      req_value = 32'd0;
      req_last = 1'b0;
      rsp_stall = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Rounding halves with the reset reciprocal of 1.0, non-finite samples, overflow.
      send_item(OP_QUANT, 32'h4020_0000, 1'b0);   // 2.5
      send_item(OP_QUANT, 32'hC020_0000, 1'b1);   // -2.5
      send_item(OP_QUANT, 32'h3F00_0000, 1'b0);   // 0.5
      send_item(OP_QUANT, 32'h3EFF_FFFF, 1'b0);   // just below 0.5
      send_item(OP_QUANT, 32'h42FD_0000, 1'b0);   // 126.5
      send_item(OP_QUANT, 32'hFF7F_FFFF, 1'b0);   // most negative finite
      send_item(OP_QUANT, 32'h7F80_0000, 1'b0);   // infinity
      send_item(OP_QUANT, 32'hFFC0_0001, 1'b0);   // NaN
      // A scan of a negative zero, a NaN and the smallest subnormal falls back to a maximum of 1.0.
      send_item(OP_SCAN, 32'h8000_0000, 1'b0);
      send_item(OP_SCAN, 32'h7FC0_0000, 1'b0);
      send_item(OP_SCAN, 32'h0000_0001, 1'b1);
      send_item(OP_SCAN, 32'hFF80_0000, 1'b0);
      send_item(OP_SCAN, 32'hFF7F_FFFF, 1'b1);    // largest magnitude
      send_item(OP_QUANT, 32'h7F7F_FFFF, 1'b0);
      // Load-scale: ignored for zero, subnormal, infinity and NaN scales.
      send_item(OP_LOAD, 32'h0000_0000, 1'b1);
      send_item(OP_LOAD, 32'h007F_FFFF, 1'b0);
      send_item(OP_LOAD, 32'h7F80_0000, 1'b0);
      send_item(OP_LOAD, 32'h7FFF_FFFF, 1'b0);
      send_item(OP_QUANT, 32'h3F80_0000, 1'b0);
      send_item(OP_LOAD, 32'hBF00_0000, 1'b0);    // negative scale -0.5
      send_item(OP_QUANT, 32'h4000_0000, 1'b1);
      send_item(OP_LOAD, 32'h0080_0000, 1'b0);    // smallest normal, huge reciprocal
      send_item(OP_QUANT, 32'h0000_0001, 1'b0);
      send_item(OP_LOAD, 32'h7F7F_FFFF, 1'b0);    // reciprocal becomes subnormal
      send_item(OP_NONE, 32'hFFFF_FFFF, 1'b1);
      send_item(OP_QUANT, 32'h7F7F_FFFF, 1'b0);

      send_idle_pct = 34;
      recv_stall_pct = 55;
      random_part(500);
      // Hold the sender until every outstanding result is back.
      wait_drained();
      send_idle_pct = 55;
      recv_stall_pct = 34;
      random_part(975);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      random_part(1450);

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Covered %0d input items: %0d scale results and %0d quantized elements,",
               items_sent, sb.scale_count, sb.quant_count);
      $display("with random idling on both channels and a drained pause mid-run.");
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("absmax_int8_quantizer verification clean");
      end else begin
         $display("absmax_int8_quantizer verification failed");
      end
      $finish;
   end
endmodule
